// ===== rtl/core/dmac_pkg.sv =====
// ----------------------------------------------------------------------------
// dmac_pkg
// Shared types and constants of the debug module register file and the
// abstract-command engine.
// ----------------------------------------------------------------------------
package dmac_pkg;

    // One input beat: an optional register access plus the hart status masks and the port status.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  reg_addr;
        logic [31:0] write_data;
        logic [3:0]  halted_mask;
        logic [3:0]  available_mask;
        logic        port_req_ready;
        logic        port_resp_valid;
        logic        port_resp_error;
        logic [63:0] port_read_data;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic [31:0] read_data;
        logic        port_req_valid;
        logic [4:0]  port_req_kind;
        logic [63:0] port_addr;
        logic [63:0] port_wdata;
        logic [2:0]  port_size;
        logic        port_resp_ready;
        logic [3:0]  hart_requests;
        logic        system_reset;
        logic [1:0]  hart_select;
    } t_out;

    // Executor phases.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_INIT  = 3'd1,
        PH_REQ   = 3'd2,
        PH_RESP  = 3'd3,
        PH_WAITH = 3'd4
    } t_phase;

    // Access opcodes.
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register addresses.
    localparam logic [6:0] A_DATA0        = 7'h04;
    localparam logic [6:0] A_DMCONTROL    = 7'h10;
    localparam logic [6:0] A_DMSTATUS     = 7'h11;
    localparam logic [6:0] A_HARTINFO     = 7'h12;
    localparam logic [6:0] A_ABSTRACTCS   = 7'h16;
    localparam logic [6:0] A_COMMAND      = 7'h17;
    localparam logic [6:0] A_ABSTRACTAUTO = 7'h18;
    localparam logic [2:0] A_PROGBUF_HI   = 3'h2;
    localparam logic [6:0] A_HALTSUM0     = 7'h40;

    // Command error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BUSY       = 3'd1;
    localparam logic [2:0] ERR_EXCEPTION  = 3'd3;
    localparam logic [2:0] ERR_HALTRESUME = 3'd4;
    localparam logic [2:0] ERR_BUS        = 3'd5;

    // Command types.
    localparam logic [7:0] CT_REG   = 8'd0;
    localparam logic [7:0] CT_QUICK = 8'd1;
    localparam logic [7:0] CT_MEM   = 8'd2;

    // Control flag bit positions.
    localparam int F_HALTREQ   = 0;
    localparam int F_RESUMEREQ = 1;
    localparam int F_RESUMEACK = 2;
    localparam int F_HARTRESET = 3;
    localparam int F_RESETHALT = 4;
    localparam int F_NDMRESET  = 5;
    localparam int F_DMACTIVE  = 6;
    localparam int F_REQVALID  = 7;
    localparam int F_RESPREADY = 8;

    // Command kind bit positions.
    localparam int K_REG     = 0;
    localparam int K_QUICK   = 1;
    localparam int K_MEM     = 2;
    localparam int K_PROG    = 3;
    localparam int K_READ    = 4;
    localparam int K_WRITE   = 5;
    localparam int K_POSTINC = 6;
    localparam int K_VIRT    = 7;

endpackage

// ===== rtl/core/dmac_step.sv =====
// ----------------------------------------------------------------------------
// dmac_step
// Next-state logic of one tick: register access decode, then one step of the
// abstract-command executor, which overrides same-tick register writes.
// ----------------------------------------------------------------------------
module dmac_step #(
    parameter int HART_COUNT    = 4,
    parameter int PROGBUF_WORDS = 8,
    parameter int PBW           = (PROGBUF_WORDS > 1) ? $clog2(PROGBUF_WORDS) : 1
) (
    input  dmac_pkg::t_in                  i_in,
    input  logic [3:0][31:0]               i_data,
    input  logic [PROGBUF_WORDS-1:0][31:0] i_pb,
    input  logic [31:0]                    i_cmd,
    input  dmac_pkg::t_phase               i_phase,
    input  logic [2:0]                     i_err,
    input  logic [3:0]                     i_aed,
    input  logic [PROGBUF_WORDS-1:0]       i_aep,
    input  logic [8:0]                     i_flags,
    input  logic [1:0]                     i_hsel,
    input  logic [7:0]                     i_kind,
    output logic [3:0][31:0]               o_data,
    output logic [PROGBUF_WORDS-1:0][31:0] o_pb,
    output logic [31:0]                    o_cmd,
    output dmac_pkg::t_phase               o_phase,
    output logic [2:0]                     o_err,
    output logic [3:0]                     o_aed,
    output logic [PROGBUF_WORDS-1:0]       o_aep,
    output logic [8:0]                     o_flags,
    output logic [1:0]                     o_hsel,
    output logic [7:0]                     o_kind,
    output logic                           o_req_load,
    output logic [63:0]                    o_req_addr,
    output logic [63:0]                    o_req_data,
    output logic [2:0]                     o_req_size,
    output logic [31:0]                    o_rd
);
    import dmac_pkg::*;

    // Status bit of one hart; harts beyond the count read as zero.
    function automatic logic hbit(input logic [3:0] m, input logic [1:0] h);
        return (32'(h) < HART_COUNT) ? m[h] : 1'b0;
    endfunction

    logic        busy;
    logic        acc;
    logic        wr;
    logic [31:0] wd;
    logic [1:0]  nh;
    logic [3:0]  t;
    logic        av;
    logic        ht;
    logic        na;
    logic        run;
    logic        hlt;
    logic        ack;
    logic        aexec;
    logic [7:0]  ctype;
    logic [1:0]  sz;
    logic [63:0] inc_addr;
    logic [3:0]  hmask;

    always_comb begin
        for (int h = 0; h < 4; h++) begin
            hmask[h] = (h < HART_COUNT);
        end
    end

    assign busy     = (i_phase != PH_IDLE);
    assign acc      = (i_in.opcode == OP_READ) || (i_in.opcode == OP_WRITE);
    assign wr       = (i_in.opcode == OP_WRITE);
    assign wd       = i_in.write_data;
    assign nh       = wd[17:16];
    assign t        = i_in.reg_addr[3:0];
    assign av       = hbit(i_in.available_mask, i_hsel);
    assign ht       = hbit(i_in.halted_mask, i_hsel);
    assign na       = !av;
    assign run      = !ht && av;
    assign hlt      = ht && av;
    assign ack      = i_flags[F_RESUMEACK];
    assign ctype    = i_cmd[31:24];
    assign sz       = i_cmd[21:20];
    assign inc_addr = {i_data[3], i_data[2]} + (64'd1 << sz);

    always_comb begin
        o_data     = i_data;
        o_pb       = i_pb;
        o_cmd      = i_cmd;
        o_phase    = i_phase;
        o_err      = i_err;
        o_aed      = i_aed;
        o_aep      = i_aep;
        o_flags    = i_flags;
        o_hsel     = i_hsel;
        o_kind     = i_kind;
        o_req_load = 1'b0;
        o_req_addr = 64'd0;
        o_req_data = 64'd0;
        o_req_size = 3'd0;
        o_rd       = 32'd0;
        aexec      = 1'b0;

        // Pending halt and resume requests retire on hart status.
        if (i_flags[F_HALTREQ] && ht) begin
            o_flags[F_HALTREQ] = 1'b0;
        end
        if (i_flags[F_RESUMEREQ] && !ht) begin
            o_flags[F_RESUMEREQ] = 1'b0;
            o_flags[F_RESUMEACK] = 1'b1;
        end

        // Register access.
        if (acc) begin
            if (i_in.reg_addr[6:2] == A_DATA0[6:2]) begin
                o_rd = i_data[i_in.reg_addr[1:0]];
                if (wr) begin
                    o_data[i_in.reg_addr[1:0]] = wd;
                end
                aexec = i_aed[i_in.reg_addr[1:0]];
            end else if (i_in.reg_addr == A_DMCONTROL) begin
                o_rd = {2'b0, i_flags[F_HARTRESET], 11'b0, i_hsel, 14'b0,
                        i_flags[F_NDMRESET], i_flags[F_DMACTIVE]};
                if (wr) begin
                    if (wd[31]) begin
                        if (hbit(i_in.halted_mask, nh)) begin
                            o_err = ERR_HALTRESUME;
                        end else begin
                            o_flags[F_HALTREQ] = 1'b1;
                        end
                    end else if (wd[30]) begin
                        if (hbit(i_in.halted_mask, nh)) begin
                            o_flags[F_RESUMEREQ] = 1'b1;
                            o_flags[F_RESUMEACK] = 1'b0;
                        end else begin
                            o_err = ERR_HALTRESUME;
                        end
                    end
                    o_flags[F_HARTRESET] = wd[29];
                    o_hsel = nh;
                    if (wd[3]) begin
                        o_flags[F_RESETHALT] = 1'b1;
                    end else if (wd[2]) begin
                        o_flags[F_RESETHALT] = 1'b0;
                    end
                    o_flags[F_NDMRESET] = wd[1];
                    o_flags[F_DMACTIVE] = wd[0];
                end
            end else if (i_in.reg_addr == A_DMSTATUS) begin
                o_rd = {14'b0, ack, ack, na, na, na, na, run, run, hlt, hlt,
                        1'b1, 1'b0, 1'b1, 3'b0, 2'b10};
            end else if (i_in.reg_addr == A_HARTINFO) begin
                o_rd = av ? (32'h2 << 20) : 32'd0;
            end else if (i_in.reg_addr == A_ABSTRACTCS) begin
                o_rd = {3'b0, 5'(PROGBUF_WORDS), 11'b0, busy, 1'b0, i_err, 8'h04};
                if (wr && (wd[10:8] != 3'd0)) begin
                    o_err = ERR_NONE;
                end
            end else if (i_in.reg_addr == A_COMMAND) begin
                if (wr && (i_err == ERR_NONE)) begin
                    if (busy) begin
                        o_err = ERR_BUSY;
                    end else begin
                        o_cmd   = wd;
                        o_phase = PH_INIT;
                    end
                end
            end else if (i_in.reg_addr == A_ABSTRACTAUTO) begin
                o_rd = 32'({12'b0, i_aed}) | (32'(i_aep) << 16);
                if (wr) begin
                    o_aed = wd[3:0];
                    o_aep = wd[16 +: PROGBUF_WORDS];
                end
            end else if (i_in.reg_addr[6:4] == A_PROGBUF_HI) begin
                if (32'(t) < PROGBUF_WORDS) begin
                    o_rd = i_pb[t[PBW-1:0]];
                    if (wr) begin
                        o_pb[t[PBW-1:0]] = wd;
                    end
                    aexec = i_aep[t[PBW-1:0]];
                end
            end else if (i_in.reg_addr == A_HALTSUM0) begin
                o_rd = {28'b0, i_in.halted_mask & hmask};
            end
        end

        // Autoexec starts the stored command again.
        if (aexec && (i_err == ERR_NONE)) begin
            if (busy) begin
                o_err = ERR_BUSY;
            end else begin
                o_phase = PH_INIT;
            end
        end

        // One executor step; its writes win over the access above.
        case (i_phase)
            PH_IDLE: begin
                o_kind = 8'd0;
                o_flags[F_REQVALID]  = 1'b0;
                o_flags[F_RESPREADY] = 1'b0;
            end
            PH_INIT: begin
                o_kind[K_POSTINC] = i_cmd[19];
                if (ctype == CT_REG) begin
                    if (i_cmd[17]) begin
                        o_phase = PH_REQ;
                        o_kind[K_REG]   = 1'b1;
                        o_kind[K_WRITE] = i_cmd[16];
                        o_kind[K_READ]  = !i_cmd[16];
                        o_flags[F_REQVALID] = 1'b1;
                        o_req_load = 1'b1;
                        o_req_addr = {48'd0, i_cmd[15:0]};
                        o_req_data = {i_data[1], i_data[0]};
                        o_req_size = i_cmd[22:20];
                    end else if (i_cmd[18]) begin
                        o_phase = PH_REQ;
                        o_flags[F_REQVALID] = 1'b1;
                        o_kind[K_PROG] = 1'b1;
                    end else begin
                        o_phase = PH_IDLE;
                    end
                end else if (ctype == CT_QUICK) begin
                    if (ht) begin
                        o_err   = ERR_HALTRESUME;
                        o_phase = PH_IDLE;
                    end else begin
                        o_flags[F_HALTREQ] = 1'b1;
                        o_kind[K_QUICK] = 1'b1;
                        o_phase = PH_WAITH;
                    end
                end else if (ctype == CT_MEM) begin
                    o_phase = PH_REQ;
                    o_kind[K_MEM]   = 1'b1;
                    o_kind[K_WRITE] = i_cmd[16];
                    o_kind[K_READ]  = !i_cmd[16];
                    o_kind[K_VIRT]  = i_cmd[23];
                    o_flags[F_REQVALID] = 1'b1;
                    o_req_load = 1'b1;
                    o_req_addr = {i_data[3], i_data[2]};
                    o_req_data = {i_data[1], i_data[0]};
                    o_req_size = i_cmd[22:20];
                end else begin
                    o_phase = PH_IDLE;
                end
            end
            PH_REQ: begin
                if (i_in.port_req_ready) begin
                    o_phase = PH_RESP;
                    o_flags[F_REQVALID]  = 1'b0;
                    o_flags[F_RESPREADY] = 1'b1;
                end
            end
            PH_RESP: begin
                if (i_in.port_resp_valid) begin
                    o_flags[F_RESPREADY] = 1'b0;
                    // Read data lands in data0/data1 by size; wide codes leave them.
                    if (i_kind[K_READ] && !i_cmd[22]) begin
                        case (sz)
                            2'd0: o_data[0] = {24'd0, i_in.port_read_data[7:0]};
                            2'd1: o_data[0] = {16'd0, i_in.port_read_data[15:0]};
                            default: o_data[0] = i_in.port_read_data[31:0];
                        endcase
                        o_data[1] = (sz == 2'd3) ? i_in.port_read_data[63:32] : 32'd0;
                    end
                    if (i_kind[K_POSTINC]) begin
                        o_kind[K_POSTINC] = 1'b0;
                        if (ctype == CT_REG) begin
                            o_cmd = {i_cmd[31:16], i_cmd[15:0] + 16'd1};
                        end else if ((ctype == CT_MEM) && !i_cmd[22]) begin
                            o_data[2] = inc_addr[31:0];
                            o_data[3] = inc_addr[63:32];
                        end
                    end
                    if (i_in.port_resp_error) begin
                        o_phase = PH_IDLE;
                        o_err   = i_kind[K_MEM] ? ERR_BUS : ERR_EXCEPTION;
                    end else if (i_kind[K_REG] && i_cmd[18]) begin
                        o_flags[F_REQVALID] = 1'b1;
                        o_kind[K_PROG]  = 1'b1;
                        o_kind[K_REG]   = 1'b0;
                        o_kind[K_WRITE] = 1'b0;
                        o_kind[K_READ]  = 1'b0;
                        o_phase = PH_REQ;
                    end else begin
                        o_phase = PH_IDLE;
                    end
                    if (i_kind[K_QUICK]) begin
                        o_flags[F_RESUMEREQ] = 1'b1;
                        o_flags[F_RESUMEACK] = 1'b0;
                    end
                end
            end
            PH_WAITH: begin
                if (ht) begin
                    o_phase = PH_REQ;
                    o_flags[F_REQVALID] = 1'b1;
                    o_kind[K_PROG] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/debug_module_abstract_commands.sv =====
// ----------------------------------------------------------------------------
// debug_module_abstract_commands
// Debug module register file with abstract-command engine, one tick per beat.
// ----------------------------------------------------------------------------
// Usage: each input beat on i_in (valid/ready) is one tick of the module. It
// may carry a debug register read or write and always carries the hart
// status masks and the debug port handshake. Each beat yields exactly one
// result beat on o_out: the register read value plus the port request, hart
// requests, system reset and hart select as they stood at the start of the
// tick.
// The result is registered at the edge that accepts the beat. A new beat is
// accepted every cycle while the receiver does not stall; the single output
// register lets the next beat in while a result is being taken in the same cycle.
// Throughput is one beat per cycle, set by the state update, which is one
// pass of decode and executor logic into the state registers.
// When the receiver stalls, the result holds and the input is not accepted.
// Reset clears the state registers, leaves the executor idle and drops o_out_valid.
// ----------------------------------------------------------------------------
module debug_module_abstract_commands #(
    parameter int HART_COUNT    = 4,
    parameter int PROGBUF_WORDS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dmac_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dmac_pkg::t_out o_out
);
    import dmac_pkg::*;

    logic [3:0][31:0]               r_data,  n_data;
    logic [PROGBUF_WORDS-1:0][31:0] r_pb,    n_pb;
    logic [31:0]                    r_cmd,   n_cmd;
    t_phase                         r_phase, n_phase;
    logic [2:0]                     r_err,   n_err;
    logic [3:0]                     r_aed,   n_aed;
    logic [PROGBUF_WORDS-1:0]       r_aep,   n_aep;
    logic [8:0]                     r_flags, n_flags;
    logic [1:0]                     r_hsel,  n_hsel;
    logic [7:0]                     r_kind,  n_kind;
    logic [63:0]                    r_raddr, n_raddr;
    logic [63:0]                    r_rdata, n_rdata;
    logic [2:0]                     r_rsize, n_rsize;
    logic                           req_load;
    logic [31:0]                    rd;
    logic                           r_out_valid;
    t_out                           r_out;
    logic                           acc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Next state of one tick.
    dmac_step #(
        .HART_COUNT    (HART_COUNT),
        .PROGBUF_WORDS (PROGBUF_WORDS)
    ) u_step (
        .i_in       (i_in),
        .i_data     (r_data),
        .i_pb       (r_pb),
        .i_cmd      (r_cmd),
        .i_phase    (r_phase),
        .i_err      (r_err),
        .i_aed      (r_aed),
        .i_aep      (r_aep),
        .i_flags    (r_flags),
        .i_hsel     (r_hsel),
        .i_kind     (r_kind),
        .o_data     (n_data),
        .o_pb       (n_pb),
        .o_cmd      (n_cmd),
        .o_phase    (n_phase),
        .o_err      (n_err),
        .o_aed      (n_aed),
        .o_aep      (n_aep),
        .o_flags    (n_flags),
        .o_hsel     (n_hsel),
        .o_kind     (n_kind),
        .o_req_load (req_load),
        .o_req_addr (n_raddr),
        .o_req_data (n_rdata),
        .o_req_size (n_rsize),
        .o_rd       (rd)
    );

    // State registers advance once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data  <= '0;
            r_pb    <= '0;
            r_cmd   <= '0;
            r_phase <= PH_IDLE;
            r_err   <= ERR_NONE;
            r_aed   <= '0;
            r_aep   <= '0;
            r_flags <= '0;
            r_hsel  <= '0;
            r_kind  <= '0;
            r_raddr <= '0;
            r_rdata <= '0;
            r_rsize <= '0;
        end else if (acc) begin
            r_data  <= n_data;
            r_pb    <= n_pb;
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_err   <= n_err;
            r_aed   <= n_aed;
            r_aep   <= n_aep;
            r_flags <= n_flags;
            r_hsel  <= n_hsel;
            r_kind  <= n_kind;
            if (req_load) begin
                r_raddr <= n_raddr;
                r_rdata <= n_rdata;
                r_rsize <= n_rsize;
            end
        end
    end

    // Result register: outputs reflect the state at the start of the tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out.read_data       <= rd;
            r_out.port_req_valid  <= r_flags[F_REQVALID];
            r_out.port_req_kind   <= {r_kind[K_PROG], r_kind[K_VIRT], r_kind[K_MEM],
                                      r_kind[K_REG], r_kind[K_WRITE]};
            r_out.port_addr       <= r_raddr;
            r_out.port_wdata      <= r_rdata;
            r_out.port_size       <= r_rsize;
            r_out.port_resp_ready <= r_flags[F_RESPREADY];
            r_out.hart_requests   <= {r_flags[F_HARTRESET], r_flags[F_RESETHALT],
                                      r_flags[F_RESUMEREQ], r_flags[F_HALTREQ]};
            r_out.system_reset    <= r_flags[F_NDMRESET];
            r_out.hart_select     <= r_hsel;
        end
    end

    // An accepted beat always produces a result beat.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted beat produced no result");

    // A stalled result keeps its value.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out))
        else $error("stalled result changed");

    // An idle tick clears the command kind.
    a_idle_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (r_phase == PH_IDLE)) |=> (r_kind == 8'd0))
        else $error("command kind not cleared in idle");

    // A port request is only pending in the request phase.
    a_req_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[F_REQVALID] |-> (r_phase == PH_REQ))
        else $error("port request pending outside request phase");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debug module testbench
// Drives register accesses and port handshakes as one beat per tick and
// compares every result beat against a behavioral model of the debug module.
// ----------------------------------------------------------------------------
module tb_top;
    import dmac_pkg::*;

    localparam int NUM_RANDOM = 500;
    localparam int NUM_DIRECTED = 20;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    debug_module_abstract_commands DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    // Model state of the debug module.
    logic [31:0] m_data [4];
    logic [31:0] m_pbuf [8];
    logic [31:0] m_cmd;
    t_phase      m_phase;
    logic [2:0]  m_err;
    logic [3:0]  m_auto_data;
    logic [7:0]  m_auto_pbuf;
    logic [8:0]  m_flags;
    logic [1:0]  m_hsel;
    logic [7:0]  m_kind;
    logic [63:0] m_addr;
    logic [63:0] m_wdata;
    logic [2:0]  m_size;

    t_out expected_beats[$];
    int   errors;
    bit   driving_done;
    bit   hold_off;
    bit   no_idle;

    // Directed table: stimulus and optionally a known read value.
    typedef struct {
        t_in         beat;
        bit          check_rd;
        logic [31:0] rd;
    } t_row;
    t_row rows[NUM_DIRECTED];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic hbit(logic [3:0] mask, logic [1:0] h);
        return mask[h];
    endfunction

    task automatic model_reset();
        for (int i = 0; i < 4; i++) m_data[i] = '0;
        for (int i = 0; i < 8; i++) m_pbuf[i] = '0;
        m_cmd = '0; m_phase = PH_IDLE; m_err = ERR_NONE;
        m_auto_data = '0; m_auto_pbuf = '0; m_flags = '0; m_hsel = '0;
        m_kind = '0; m_addr = '0; m_wdata = '0; m_size = '0;
    endtask

    // Autoexec trigger from a data or progbuf access.
    task automatic trigger_autoexec(logic [2:0] old_err, bit busy);
        if (old_err == ERR_NONE) begin
            if (busy) m_err = ERR_BUSY;
            else m_phase = PH_INIT;
        end
    endtask

    // One tick of the debug module; returns the result beat.
    task automatic debug_tick(input t_in b, output t_out r);
        logic [31:0] od [4];
        logic [31:0] ocmd;
        t_phase      ophase;
        logic [2:0]  oerr;
        logic [7:0]  okind;
        logic [8:0]  oflags;
        logic [1:0]  hs;
        logic [1:0]  nh;
        logic [31:0] wd;
        logic [3:0]  pi;
        logic [7:0]  ctype;
        logic [2:0]  sz;
        logic [63:0] a;
        bit          busy;
        bit          wr;
        bit          av;
        bit          ht;
        bit          ack;
        bit          na;
        bit          run;
        bit          hlt;
        for (int i = 0; i < 4; i++) od[i] = m_data[i];
        ocmd = m_cmd; ophase = m_phase; oerr = m_err; okind = m_kind;
        oflags = m_flags; hs = m_hsel; busy = (ophase != PH_IDLE);
        wd = b.write_data;
        r = '0;
        r.port_req_valid = oflags[F_REQVALID];
        r.port_req_kind = {okind[K_PROG], okind[K_VIRT], okind[K_MEM],
                           okind[K_REG], okind[K_WRITE]};
        r.port_addr = m_addr;
        r.port_wdata = m_wdata;
        r.port_size = m_size;
        r.port_resp_ready = oflags[F_RESPREADY];
        r.hart_requests = {oflags[F_HARTRESET], oflags[F_RESETHALT],
                           oflags[F_RESUMEREQ], oflags[F_HALTREQ]};
        r.system_reset = oflags[F_NDMRESET];
        r.hart_select = hs;

        if (oflags[F_HALTREQ] && hbit(b.halted_mask, hs)) m_flags[F_HALTREQ] = 1'b0;
        if (oflags[F_RESUMEREQ] && !hbit(b.halted_mask, hs)) begin
            m_flags[F_RESUMEREQ] = 1'b0;
            m_flags[F_RESUMEACK] = 1'b1;
        end

        // Register access.
        if (b.opcode == OP_READ || b.opcode == OP_WRITE) begin
            wr = (b.opcode == OP_WRITE);
            if (b.reg_addr >= A_DATA0 && b.reg_addr <= A_DATA0 + 3) begin
                r.read_data = od[b.reg_addr[1:0]];
                if (wr) m_data[b.reg_addr[1:0]] = wd;
                if (m_auto_data[b.reg_addr[1:0]]) trigger_autoexec(oerr, busy);
            end else if (b.reg_addr == A_DMCONTROL) begin
                r.read_data = {2'b0, oflags[F_HARTRESET], 11'b0, hs, 14'b0,
                               oflags[F_NDMRESET], oflags[F_DMACTIVE]};
                if (wr) begin
                    nh = wd[17:16];
                    if (wd[31]) begin
                        if (hbit(b.halted_mask, nh)) m_err = ERR_HALTRESUME;
                        else m_flags[F_HALTREQ] = 1'b1;
                    end else if (wd[30]) begin
                        if (hbit(b.halted_mask, nh)) begin
                            m_flags[F_RESUMEREQ] = 1'b1;
                            m_flags[F_RESUMEACK] = 1'b0;
                        end else begin
                            m_err = ERR_HALTRESUME;
                        end
                    end
                    m_flags[F_HARTRESET] = wd[29];
                    m_hsel = nh;
                    if (wd[3]) m_flags[F_RESETHALT] = 1'b1;
                    else if (wd[2]) m_flags[F_RESETHALT] = 1'b0;
                    m_flags[F_NDMRESET] = wd[1];
                    m_flags[F_DMACTIVE] = wd[0];
                end
            end else if (b.reg_addr == A_DMSTATUS) begin
                av = hbit(b.available_mask, hs);
                ht = hbit(b.halted_mask, hs);
                ack = oflags[F_RESUMEACK];
                na = !av; run = !ht && av; hlt = ht && av;
                r.read_data = {14'b0, ack, ack, na, na, na, na, run, run, hlt, hlt,
                               1'b1, 1'b0, 1'b1, 3'b0, 2'b10};
            end else if (b.reg_addr == A_HARTINFO) begin
                if (hbit(b.available_mask, hs)) r.read_data = 32'h2 << 20;
            end else if (b.reg_addr == A_ABSTRACTCS) begin
                r.read_data = (32'd8 << 24) | (busy ? (32'd1 << 12) : 32'd0) |
                              (32'(oerr) << 8) | 32'd4;
                if (wr && wd[10:8] != 3'd0) m_err = ERR_NONE;
            end else if (b.reg_addr == A_COMMAND) begin
                if (wr && oerr == ERR_NONE) begin
                    if (busy) m_err = ERR_BUSY;
                    else begin
                        m_cmd = wd;
                        m_phase = PH_INIT;
                    end
                end
            end else if (b.reg_addr == A_ABSTRACTAUTO) begin
                r.read_data = {8'b0, m_auto_pbuf, 12'b0, m_auto_data};
                if (wr) begin
                    m_auto_data = wd[3:0];
                    m_auto_pbuf = wd[23:16];
                end
            end else if (b.reg_addr[6:4] == A_PROGBUF_HI) begin
                pi = b.reg_addr[3:0];
                if (pi < 8) begin
                    r.read_data = m_pbuf[pi[2:0]];
                    if (wr) m_pbuf[pi[2:0]] = wd;
                    if (m_auto_pbuf[pi[2:0]]) trigger_autoexec(oerr, busy);
                end
            end else if (b.reg_addr == A_HALTSUM0) begin
                r.read_data = {28'b0, b.halted_mask};
            end
        end

        // Executor step.
        ctype = ocmd[31:24];
        sz = ocmd[22:20];
        case (ophase)
            PH_IDLE: begin
                m_kind = '0;
                m_flags[F_REQVALID] = 1'b0;
                m_flags[F_RESPREADY] = 1'b0;
            end
            PH_INIT: begin
                m_kind[K_POSTINC] = ocmd[19];
                if (ctype == CT_REG) begin
                    if (ocmd[17]) begin
                        m_phase = PH_REQ;
                        m_kind[K_REG] = 1'b1;
                        m_kind[K_WRITE] = ocmd[16];
                        m_kind[K_READ] = !ocmd[16];
                        m_flags[F_REQVALID] = 1'b1;
                        m_addr = {48'b0, ocmd[15:0]};
                        m_wdata = {od[1], od[0]};
                        m_size = sz;
                    end else if (ocmd[18]) begin
                        m_phase = PH_REQ;
                        m_flags[F_REQVALID] = 1'b1;
                        m_kind[K_PROG] = 1'b1;
                    end else begin
                        m_phase = PH_IDLE;
                    end
                end else if (ctype == CT_QUICK) begin
                    if (hbit(b.halted_mask, hs)) begin
                        m_err = ERR_HALTRESUME;
                        m_phase = PH_IDLE;
                    end else begin
                        m_flags[F_HALTREQ] = 1'b1;
                        m_kind[K_QUICK] = 1'b1;
                        m_phase = PH_WAITH;
                    end
                end else if (ctype == CT_MEM) begin
                    m_phase = PH_REQ;
                    m_kind[K_MEM] = 1'b1;
                    m_kind[K_WRITE] = ocmd[16];
                    m_kind[K_READ] = !ocmd[16];
                    m_kind[K_VIRT] = ocmd[23];
                    m_flags[F_REQVALID] = 1'b1;
                    m_addr = {od[3], od[2]};
                    m_wdata = {od[1], od[0]};
                    m_size = sz;
                end else begin
                    m_phase = PH_IDLE;
                end
            end
            PH_REQ: begin
                if (b.port_req_ready) begin
                    m_phase = PH_RESP;
                    m_flags[F_REQVALID] = 1'b0;
                    m_flags[F_RESPREADY] = 1'b1;
                end
            end
            PH_RESP: begin
                if (b.port_resp_valid) begin
                    m_flags[F_RESPREADY] = 1'b0;
                    if (okind[K_READ]) begin
                        case (sz)
                            3'd0: begin m_data[0] = {24'b0, b.port_read_data[7:0]}; m_data[1] = '0; end
                            3'd1: begin m_data[0] = {16'b0, b.port_read_data[15:0]}; m_data[1] = '0; end
                            3'd2: begin m_data[0] = b.port_read_data[31:0]; m_data[1] = '0; end
                            3'd3: begin
                                m_data[0] = b.port_read_data[31:0];
                                m_data[1] = b.port_read_data[63:32];
                            end
                            default: ;
                        endcase
                    end
                    if (okind[K_POSTINC]) begin
                        m_kind[K_POSTINC] = 1'b0;
                        if (ctype == CT_REG) begin
                            m_cmd = {ocmd[31:16], ocmd[15:0] + 16'd1};
                        end else if (ctype == CT_MEM && sz < 4) begin
                            a = {od[3], od[2]} + (64'd1 << sz);
                            m_data[2] = a[31:0];
                            m_data[3] = a[63:32];
                        end
                    end
                    if (b.port_resp_error) begin
                        m_phase = PH_IDLE;
                        m_err = okind[K_MEM] ? ERR_BUS : ERR_EXCEPTION;
                    end else if (okind[K_REG] && ocmd[18]) begin
                        m_flags[F_REQVALID] = 1'b1;
                        m_kind[K_PROG] = 1'b1;
                        m_kind[K_REG] = 1'b0;
                        m_kind[K_WRITE] = 1'b0;
                        m_kind[K_READ] = 1'b0;
                        m_phase = PH_REQ;
                    end else begin
                        m_phase = PH_IDLE;
                    end
                    if (okind[K_QUICK]) begin
                        m_flags[F_RESUMEREQ] = 1'b1;
                        m_flags[F_RESUMEACK] = 1'b0;
                    end
                end
            end
            PH_WAITH: begin
                if (hbit(b.halted_mask, hs)) begin
                    m_phase = PH_REQ;
                    m_flags[F_REQVALID] = 1'b1;
                    m_kind[K_PROG] = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_in make_beat(logic [1:0] op, logic [6:0] ra, logic [31:0] wd);
        t_in b;
        b.opcode = op;
        b.reg_addr = ra;
        b.write_data = wd;
        b.halted_mask = 4'($urandom);
        b.available_mask = 4'($urandom);
        b.port_req_ready = 1'($urandom);
        b.port_resp_valid = 1'($urandom);
        b.port_resp_error = ($urandom_range(0, 7) == 0);
        b.port_read_data = {$urandom, $urandom};
        return b;
    endfunction

    // Random beat, weighted toward command sequences.
    function automatic t_in random_beat();
        logic [6:0]  ra;
        logic [31:0] wd;
        int          pick;
        pick = $urandom_range(0, 99);
        wd = $urandom;
        if (pick < 20) begin
            ra = A_COMMAND;
            wd[31:24] = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) wd[31:24] = 8'($urandom);
            wd[22:20] = 3'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) wd[22:20] = 3'($urandom_range(4, 7));
        end else if (pick < 30) begin
            ra = A_ABSTRACTCS;
        end else if (pick < 45) begin
            ra = A_DATA0 + 7'($urandom_range(0, 3));
        end else if (pick < 55) begin
            ra = A_DMCONTROL;
        end else if (pick < 60) begin
            ra = A_ABSTRACTAUTO;
        end else if (pick < 70) begin
            ra = {A_PROGBUF_HI, 4'($urandom)};
        end else if (pick < 85) begin
            ra = ($urandom_range(0, 1)) ? A_DMSTATUS :
                 (($urandom_range(0, 1)) ? A_HARTINFO : A_HALTSUM0);
        end else begin
            ra = 7'($urandom);
        end
        return make_beat(2'($urandom), ra, wd);
    endfunction

    function automatic t_row row(logic [1:0] op, logic [6:0] ra, logic [31:0] wd,
                                 bit chk, logic [31:0] rd);
        t_row x;
        x.beat = make_beat(op, ra, wd);
        x.check_rd = chk;
        x.rd = rd;
        return x;
    endfunction

    // Check of each result beat.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_out);
                errors++;
            end else begin
                e = expected_beats.pop_front();
                if (o_out !== e) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, o_out);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off.
    initial begin
        int n;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready = 1'b0;
                for (n = 0; n < 60; n++) @(negedge i_clk);
                hold_off = 1'b0;
                i_out_ready = 1'b1;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Send one beat and record its expected result.
    task automatic send_beat(input t_in b, input bit chk, input logic [31:0] rd);
        t_out r;
        int   gap;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        i_in = b;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        debug_tick(b, r);
        if (chk && r.read_data !== rd) begin
            $display("%0t: table read mismatch expected %h actual %h", $time, rd, r.read_data);
            errors++;
        end
        expected_beats.push_back(r);
        @(negedge i_clk);
    endtask

    initial begin
        int wait_cycles;
        errors = 0;
        hold_off = 1'b0;
        no_idle = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_rst_n = 1'b0;
        model_reset();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        rows[0]  = row(OP_READ, A_DATA0, 32'h0, 1, 32'h0);
        rows[1]  = row(OP_WRITE, A_DATA0, 32'hFFFF_FFFF, 1, 32'h0);
        rows[2]  = row(OP_READ, A_DATA0, 32'h0, 1, 32'hFFFF_FFFF);
        rows[3]  = row(OP_READ, A_ABSTRACTCS, 32'h0, 1, 32'h0800_0004);
        rows[4]  = row(OP_WRITE, A_DMCONTROL, 32'h0003_002B, 0, 32'h0);
        rows[5]  = row(OP_READ, A_DMCONTROL, 32'h0, 0, 32'h0);
        rows[6]  = row(OP_WRITE, A_ABSTRACTAUTO, 32'hFFFF_FFFF, 1, 32'h0);
        rows[7]  = row(OP_READ, A_ABSTRACTAUTO, 32'h0, 1, 32'h00FF_000F);
        rows[8]  = row(OP_WRITE, 7'h2F, 32'hDEAD_BEEF, 1, 32'h0);
        rows[9]  = row(OP_WRITE, 7'h27, 32'h1234_5678, 1, 32'h0);
        rows[10] = row(OP_WRITE, A_ABSTRACTAUTO, 32'h0, 0, 32'h0);
        rows[11] = row(OP_WRITE, A_COMMAND, 32'h0233_1000, 0, 32'h0);
        rows[12] = row(OP_WRITE, A_COMMAND, 32'h0232_1000, 0, 32'h0);
        rows[13] = row(OP_WRITE, A_ABSTRACTCS, 32'h0000_0700, 0, 32'h0);
        rows[14] = row(OP_WRITE, A_COMMAND, 32'h0282_0000, 0, 32'h0);
        rows[15] = row(OP_WRITE, A_COMMAND, 32'h0100_0000, 0, 32'h0);
        rows[16] = row(OP_WRITE, A_COMMAND, 32'hFF00_0000, 0, 32'h0);
        rows[17] = row(2'd3, A_DMSTATUS, 32'hFFFF_FFFF, 1, 32'h0);
        rows[18] = row(OP_READ, 7'h7F, 32'h0, 1, 32'h0);
        rows[19] = row(OP_READ, A_HALTSUM0, 32'h0, 0, 32'h0);
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_beat(rows[i].beat, rows[i].check_rd, rows[i].rd);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 150) hold_off = 1'b1;
            if (i == NUM_RANDOM - 60) no_idle = 1'b1;
            send_beat(random_beat(), 0, 32'h0);
        end
        i_in_valid = 1'b0;

        wait_cycles = 0;
        while (expected_beats.size() != 0 && wait_cycles < 2000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (5) @(negedge i_clk);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
